FILE: sv/m4i_pkg.sv
// Shared types, constants and arithmetic helpers for the 4x4 matrix inverse block.
package m4i_pkg;

  localparam int unsigned WORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned ACC_W          = 64;
  localparam int unsigned N_ELEM         = 16;
  localparam int unsigned N_PERM         = 6;

  typedef logic [3:0]       idx_t;
  typedef logic [ACC_W-1:0] acc_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam idx_t IDX_LAST = idx_t'(N_ELEM - 1);
  localparam logic [2:0] PERM_LAST = 3'(N_PERM - 1);
  localparam logic [2:0] PERM_SPLIT = 3'(N_PERM / 2);

  // Operand source of the shared multiplier
  typedef enum logic [1:0] {
    MS_AB  = 2'd0,
    MS_TC  = 2'd1,
    MS_DET = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     mat_we;
    idx_t     mat_raddr;
    idx_t     cof_raddr;
    logic     cof_we;
    idx_t     cof_waddr;
    logic     lat_a;
    logic     lat_b;
    logic     lat_c;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     acc_clr;
    logic     acc_en;
    logic     acc_sub;
    logic     csat_or;
    logic     det_clr;
    logic     det_en;
    logic     div_start;
    logic     out_load;
    idx_t     out_index;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic det_zero;
  } dp_stat_t;

  // Magnitude of a signed word as an unsigned word
  function automatic acc_t mag_of(acc_t v);
    return v[ACC_W-1] ? acc_t'(-v) : v;
  endfunction

  // Saturating add or subtract; returns {overflow, value}
  function automatic logic [ACC_W:0] sat_addsub(acc_t a, acc_t b, logic sub);
    logic [ACC_W:0] s;
    logic           ov;
    acc_t           v;
    s  = sub ? ({a[ACC_W-1], a} - {b[ACC_W-1], b}) : ({a[ACC_W-1], a} + {b[ACC_W-1], b});
    ov = s[ACC_W] ^ s[ACC_W-1];
    v  = ov ? (s[ACC_W] ? ACC_MIN : ACC_MAX) : s[ACC_W-1:0];
    return {ov, v};
  endfunction

  // Column pick of a term of a 3x3 minor
  function automatic logic [1:0] perm_col(logic [2:0] p, logic [1:0] slot);
    logic [5:0] row;
    unique case (p)
      3'd0:    row = {2'd0, 2'd1, 2'd2};
      3'd1:    row = {2'd1, 2'd2, 2'd0};
      3'd2:    row = {2'd2, 2'd0, 2'd1};
      3'd3:    row = {2'd0, 2'd2, 2'd1};
      3'd4:    row = {2'd2, 2'd1, 2'd0};
      3'd5:    row = {2'd1, 2'd0, 2'd2};
      default: row = {2'd0, 2'd1, 2'd2};
    endcase
    unique case (slot)
      2'd0:    return row[5:4];
      2'd1:    return row[3:2];
      default: return row[1:0];
    endcase
  endfunction

  // Element address of one factor of a minor term; r and c are the struck row and column
  function automatic idx_t minor_addr(logic [1:0] r, logic [1:0] c, logic [2:0] p,
                                      logic [1:0] slot);
    logic [1:0] row;
    logic [1:0] cs;
    logic [1:0] col;
    row = (slot < r) ? slot : slot + 2'd1;
    cs  = perm_col(p, slot);
    col = (cs < c) ? cs : cs + 2'd1;
    return {row, col};
  endfunction

endpackage

FILE: sv/m4i_if.sv
// Valid/ready channel interfaces for matrix elements and inverse elements.
interface m4i_in_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] elem_value;
  logic [3:0]   elem_index;

  modport source (output valid, elem_value, elem_index, input ready);
  modport sink   (input valid, elem_value, elem_index, output ready);
endinterface

interface m4i_out_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] inv_value;
  logic [3:0]   inv_index;
  logic         last_elem;
  logic         singular;
  logic         saturated;

  modport source (output valid, inv_value, inv_index, last_elem, singular, saturated,
                  input ready);
  modport sink   (input valid, inv_value, inv_index, last_elem, singular, saturated,
                  output ready);
endinterface

FILE: sv/m4i_mul.sv
// Shared 64x64 fixed-point multiplier: four 32x32 partial products, floor scaling, saturation.
module m4i_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [m4i_pkg::ACC_W-1:0] a_i,
  input  logic [m4i_pkg::ACC_W-1:0] b_i,
  output logic [m4i_pkg::ACC_W-1:0] res_o,
  output logic                sat_o,
  output logic                done_o
);
  import m4i_pkg::*;

  localparam int unsigned HALF = ACC_W / 2;
  localparam int unsigned PW   = 2 * ACC_W;

  acc_t            ua_q, ub_q;
  logic            neg_q;
  logic [PW-1:0]   prod_q;
  logic [1:0]      cnt_q;
  logic            run_q, fin_q, done_q;
  acc_t            res_q;
  logic            sat_q;

  logic [HALF-1:0] ua_h, ub_h;
  logic [ACC_W-1:0] pp;
  logic [PW-1:0]   pp_sh;
  logic [PW-1:0]   q_sh, q_rnd;
  logic            rnd;
  logic            ovf_pos, ovf_neg;
  acc_t            res_d;
  logic            sat_d;

  // Pick halves and form one partial product
  assign ua_h = cnt_q[1] ? ua_q[ACC_W-1:HALF] : ua_q[HALF-1:0];
  assign ub_h = cnt_q[0] ? ub_q[ACC_W-1:HALF] : ub_q[HALF-1:0];
  assign pp   = ua_h * ub_h;

  always_comb begin
    unique case (cnt_q)
      2'd0:    pp_sh = PW'(pp);
      2'd3:    pp_sh = PW'(pp) << (2 * HALF);
      default: pp_sh = PW'(pp) << HALF;
    endcase
  end

  // Scale by floor, then clip to the signed 64-bit range
  always_comb begin
    q_sh    = prod_q >> FRAC_BITS;
    rnd     = neg_q & (|prod_q[FRAC_BITS-1:0]);
    q_rnd   = q_sh + PW'(rnd);
    ovf_pos = |q_rnd[PW-1:ACC_W-1];
    ovf_neg = (|q_rnd[PW-1:ACC_W]) | (q_rnd[ACC_W-1] & (|q_rnd[ACC_W-2:0]));
    sat_d   = neg_q ? ovf_neg : ovf_pos;
    if (neg_q) begin
      res_d = ovf_neg ? ACC_MIN : acc_t'(-q_rnd[ACC_W-1:0]);
    end else begin
      res_d = ovf_pos ? ACC_MAX : q_rnd[ACC_W-1:0];
    end
  end

  // Sequence the partial products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= fin_q;
      fin_q  <= run_q && (cnt_q == 2'd3);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 2'd0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // Hold operands, accumulate, latch the result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q   <= mag_of(a_i);
      ub_q   <= mag_of(b_i);
      neg_q  <= a_i[ACC_W-1] ^ b_i[ACC_W-1];
      prod_q <= '0;
    end else if (run_q) begin
      prod_q <= prod_q + pp_sh;
    end
    if (fin_q) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o  = res_q;
  assign sat_o  = sat_q;
  assign done_o = done_q;

endmodule

FILE: sv/m4i_div.sv
// Restoring divider, one quotient bit a cycle: trunc(n * 2^F / d) clipped to W bits.
module m4i_div #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [m4i_pkg::ACC_W-1:0] num_i,
  input  logic [m4i_pkg::ACC_W-1:0] den_i,
  output logic [WORD_WIDTH-1:0]     res_o,
  output logic                      sat_o,
  output logic                      done_o
);
  import m4i_pkg::*;

  localparam int unsigned NW = ACC_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW);

  logic [NW-1:0]     num_q;
  acc_t              rem_q, quo_q, ud_q;
  logic              neg_q, over_q;
  logic [CW-1:0]     cnt_q;
  logic              run_q, fin_q, done_q;
  logic [WORD_WIDTH-1:0] res_q;
  logic              sat_q;

  logic [ACC_W:0]    rem2, diff;
  logic              ge;
  acc_t              lim, qc;
  logic              clip;

  // One restoring step
  assign rem2 = {rem_q, num_q[NW-1]};
  assign diff = rem2 - {1'b0, ud_q};
  assign ge   = rem2 >= {1'b0, ud_q};

  // Clip to the signed W-bit range
  always_comb begin
    lim  = neg_q ? (acc_t'(1) << (WORD_WIDTH - 1)) : ((acc_t'(1) << (WORD_WIDTH - 1)) - acc_t'(1));
    clip = over_q || (quo_q > lim);
    qc   = clip ? lim : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= run_q && (cnt_q == '0);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(NW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= {mag_of(num_i), {FRAC_BITS{1'b0}}};
      ud_q   <= mag_of(den_i);
      neg_q  <= num_i[ACC_W-1] ^ den_i[ACC_W-1];
      rem_q  <= '0;
      quo_q  <= '0;
      over_q <= 1'b0;
    end else if (run_q) begin
      num_q  <= num_q << 1;
      rem_q  <= ge ? diff[ACC_W-1:0] : rem2[ACC_W-1:0];
      quo_q  <= {quo_q[ACC_W-2:0], ge};
      over_q <= over_q | quo_q[ACC_W-1];
    end
    if (fin_q) begin
      res_q <= neg_q ? WORD_WIDTH'(-qc) : qc[WORD_WIDTH-1:0];
      sat_q <= clip;
    end
  end

  assign res_o  = res_q;
  assign sat_o  = sat_q;
  assign done_o = done_q;

endmodule

FILE: sv/m4i_dp.sv
// Datapath: element and cofactor memories, operand registers, accumulators, shared units.
module m4i_dp #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  m4i_pkg::dp_cmd_t         cmd_i,
  output m4i_pkg::dp_stat_t        stat_o,
  input  logic [WORD_WIDTH-1:0]    elem_value_i,
  input  m4i_pkg::idx_t            elem_index_i,
  output logic [WORD_WIDTH-1:0]    inv_value_o,
  output m4i_pkg::idx_t            inv_index_o,
  output logic                     last_elem_o,
  output logic                     singular_o,
  output logic                     saturated_o
);
  import m4i_pkg::*;

  localparam int unsigned W = WORD_WIDTH;

  logic [W-1:0]   mat_mem [N_ELEM];
  logic [ACC_W:0] cof_mem [N_ELEM];
  logic [W-1:0]   mat_rdata_q;
  logic [ACC_W:0] cof_rdata_q;

  logic [W-1:0]   op_a_q, op_b_q, op_c_q;
  acc_t           acc_q, det_q;
  logic           cof_sat_q, det_sat_q;

  acc_t           mul_a, mul_b, mul_res;
  logic           mul_sat, mul_done;
  logic [W-1:0]   div_res;
  logic           div_sat, div_done;
  logic [ACC_W:0] acc_sum, det_sum;

  function automatic acc_t sext(logic [W-1:0] v);
    return {{(ACC_W-W){v[W-1]}}, v};
  endfunction

  // Element memory: write on load, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mat_we) begin
      mat_mem[elem_index_i] <= elem_value_i;
    end
    mat_rdata_q <= mat_mem[cmd_i.mat_raddr];
  end

  // Adjugate memory with its overflow flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.cof_we) begin
      cof_mem[cmd_i.cof_waddr] <= {cof_sat_q, acc_q};
    end
    cof_rdata_q <= cof_mem[cmd_i.cof_raddr];
  end

  // Capture the three factors of a term
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_a) op_a_q <= mat_rdata_q;
    if (cmd_i.lat_b) op_b_q <= mat_rdata_q;
    if (cmd_i.lat_c) op_c_q <= mat_rdata_q;
  end

  // Steer multiplier operands
  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_AB: begin
        mul_a = sext(op_a_q);
        mul_b = sext(op_b_q);
      end
      MS_TC: begin
        mul_a = mul_res;
        mul_b = sext(op_c_q);
      end
      MS_DET: begin
        mul_a = sext(mat_rdata_q);
        mul_b = cof_rdata_q[ACC_W-1:0];
      end
      default: begin
        mul_a = sext(op_a_q);
        mul_b = sext(op_b_q);
      end
    endcase
  end

  m4i_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .res_o  (mul_res),
    .sat_o  (mul_sat),
    .done_o (mul_done)
  );

  m4i_div #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (cof_rdata_q[ACC_W-1:0]),
    .den_i  (det_q),
    .res_o  (div_res),
    .sat_o  (div_sat),
    .done_o (div_done)
  );

  assign acc_sum = sat_addsub(acc_q, mul_res, cmd_i.acc_sub);
  assign det_sum = sat_addsub(det_q, mul_res, 1'b0);

  // Cofactor and determinant accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q     <= '0;
      cof_sat_q <= 1'b0;
    end else if (cmd_i.acc_en) begin
      acc_q     <= acc_sum[ACC_W-1:0];
      cof_sat_q <= cof_sat_q | mul_sat | acc_sum[ACC_W];
    end else if (cmd_i.csat_or) begin
      cof_sat_q <= cof_sat_q | mul_sat;
    end
    if (cmd_i.det_clr) begin
      det_q     <= '0;
      det_sat_q <= 1'b0;
    end else if (cmd_i.det_en) begin
      det_q     <= det_sum[ACC_W-1:0];
      det_sat_q <= det_sat_q | mul_sat | det_sum[ACC_W];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      inv_value_o <= stat_o.det_zero ? '0 : div_res;
      singular_o  <= stat_o.det_zero;
      saturated_o <= !stat_o.det_zero && (cof_rdata_q[ACC_W] | det_sat_q | div_sat);
      inv_index_o <= cmd_i.out_index;
      last_elem_o <= cmd_i.out_last;
    end
  end

  assign stat_o.mul_done = mul_done;
  assign stat_o.div_done = div_done;
  assign stat_o.det_zero = (det_q == '0);

endmodule

FILE: sv/m4i_ctrl.sv
// Controller: sequences loading, cofactor terms, determinant and the result beats.
module m4i_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  m4i_pkg::idx_t      in_index_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output m4i_pkg::dp_cmd_t   cmd_o,
  input  m4i_pkg::dp_stat_t  stat_i
);
  import m4i_pkg::*;

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_RD_A     = 16'h0002,
    ST_RD_B     = 16'h0004,
    ST_RD_C     = 16'h0008,
    ST_MUL1     = 16'h0010,
    ST_WAIT1    = 16'h0020,
    ST_WAIT2    = 16'h0040,
    ST_COF_WR   = 16'h0080,
    ST_DET_RD   = 16'h0100,
    ST_DET_MUL  = 16'h0200,
    ST_DET_WAIT = 16'h0400,
    ST_OUT_RD   = 16'h0800,
    ST_OUT_DIV  = 16'h1000,
    ST_DIV_WAIT = 16'h2000,
    ST_OUT_LOAD = 16'h4000,
    ST_SPARE    = 16'h8000
  } state_e;

  state_e     state_q, state_d;
  idx_t       cnt_q, cnt_d;
  logic [2:0] perm_q, perm_d;
  logic       out_valid_q, out_valid_d;

  logic [1:0] r, c;
  logic       in_fire, slot_free;

  assign r         = cnt_q[3:2];
  assign c         = cnt_q[1:0];
  assign in_fire   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    perm_d  = perm_q;
    cmd_o   = '0;
    cmd_o.mul_sel   = MS_AB;
    cmd_o.mat_raddr = minor_addr(r, c, perm_q, 2'd0);
    cmd_o.cof_raddr = cnt_q;
    cmd_o.cof_waddr = {c, r};
    cmd_o.acc_sub   = (perm_q < PERM_SPLIT) == (r[0] ^ c[0]);
    cmd_o.out_index = cnt_q;
    cmd_o.out_last  = (cnt_q == IDX_LAST);
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.mat_we  = in_fire;
        cmd_o.acc_clr = 1'b1;
        if (in_fire && (in_index_i == IDX_LAST)) begin
          cnt_d   = '0;
          perm_d  = '0;
          state_d = ST_RD_A;
        end
      end
      ST_RD_A: state_d = ST_RD_B;
      ST_RD_B: begin
        cmd_o.mat_raddr = minor_addr(r, c, perm_q, 2'd1);
        cmd_o.lat_a     = 1'b1;
        state_d         = ST_RD_C;
      end
      ST_RD_C: begin
        cmd_o.mat_raddr = minor_addr(r, c, perm_q, 2'd2);
        cmd_o.lat_b     = 1'b1;
        state_d         = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.lat_c     = 1'b1;
        cmd_o.mul_start = 1'b1;
        state_d         = ST_WAIT1;
      end
      ST_WAIT1: begin
        cmd_o.mul_sel = MS_TC;
        if (stat_i.mul_done) begin
          cmd_o.csat_or   = 1'b1;
          cmd_o.mul_start = 1'b1;
          state_d         = ST_WAIT2;
        end
      end
      ST_WAIT2: begin
        if (stat_i.mul_done) begin
          cmd_o.acc_en = 1'b1;
          if (perm_q == PERM_LAST) begin
            perm_d  = '0;
            state_d = ST_COF_WR;
          end else begin
            perm_d  = perm_q + 3'd1;
            state_d = ST_RD_A;
          end
        end
      end
      ST_COF_WR: begin
        cmd_o.cof_we  = 1'b1;
        cmd_o.acc_clr = 1'b1;
        if (cnt_q == IDX_LAST) begin
          cnt_d         = '0;
          cmd_o.det_clr = 1'b1;
          state_d       = ST_DET_RD;
        end else begin
          cnt_d   = cnt_q + idx_t'(1);
          state_d = ST_RD_A;
        end
      end
      ST_DET_RD: begin
        cmd_o.mat_raddr = {2'd0, c};
        cmd_o.cof_raddr = {c, 2'd0};
        state_d         = ST_DET_MUL;
      end
      ST_DET_MUL: begin
        cmd_o.mul_sel   = MS_DET;
        cmd_o.mul_start = 1'b1;
        state_d         = ST_DET_WAIT;
      end
      ST_DET_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.det_en = 1'b1;
          if (c == 2'd3) begin
            cnt_d   = '0;
            state_d = ST_OUT_RD;
          end else begin
            cnt_d   = cnt_q + idx_t'(1);
            state_d = ST_DET_RD;
          end
        end
      end
      ST_OUT_RD: state_d = ST_OUT_DIV;
      ST_OUT_DIV: begin
        if (stat_i.det_zero) begin
          state_d = ST_OUT_LOAD;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (stat_i.div_done) begin
          state_d = ST_OUT_LOAD;
        end
      end
      ST_OUT_LOAD: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          if (cnt_q == IDX_LAST) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d   = cnt_q + idx_t'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output beat valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      perm_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      perm_q      <= perm_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken beat");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_last) |=> (state_q == ST_IDLE))
    else $error("run did not end after the last result");

  a_no_div_singular: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !stat_i.det_zero)
    else $error("divide started with zero determinant");

endmodule

FILE: sv/matrix4_inverse_cofactor_top.sv
// Top level of the 4x4 matrix inverse (adjugate over determinant) in signed fixed point.
//
// Usage: send matrix elements on elem_i, each beat carrying elem_value (Q16.16 by
// default) and elem_index = col + row * 4. Elements may arrive in any order and may be
// rewritten; the beat with index 15 starts a run on the current contents.
// A run emits 16 beats on inv_o in index order 0..15; last_elem marks the sixteenth.
// singular is set with zero values when the determinant is zero; saturated marks
// clipped elements or overflow in the cofactor or determinant sums.
// Loading: elem_i is always ready while idle, so element beats are taken back to back.
// After the final beat, each of the six terms of each of the 16 cofactors takes three
// element memory reads, a start step and two passes through the shared 64x64
// multiplier (four 32x32 partial products), and one more step writes the cofactor.
// The determinant then takes four multiplier passes, and each result three control
// steps plus a pass through the one-bit-per-cycle divider; a zero determinant skips
// the divider. The divider and the shared multiplier set the length of a run.
// elem_i.ready is low for the whole run. A stalled inv_o holds the current beat in
// the output register and pauses the run until it is taken.
// Reset clears the controller; the memories keep no reset value and must be loaded.
module matrix4_inverse_cofactor_top #(
  parameter int unsigned WORD_WIDTH = m4i_pkg::WORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = m4i_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  m4i_in_if.sink    elem_i,
  m4i_out_if.source inv_o
);
  import m4i_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  m4i_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (elem_i.valid),
    .in_ready_o (elem_i.ready),
    .in_index_i (elem_i.elem_index),
    .out_ready_i(inv_o.ready),
    .out_valid_o(inv_o.valid),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  m4i_dp #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .elem_value_i(elem_i.elem_value),
    .elem_index_i(elem_i.elem_index),
    .inv_value_o (inv_o.inv_value),
    .inv_index_o (inv_o.inv_index),
    .last_elem_o (inv_o.last_elem),
    .singular_o  (inv_o.singular),
    .saturated_o (inv_o.saturated)
  );

endmodule
